// ===== design/segx_pkg.sv =====
// shared constants and types for the segment crossing block
package segx_pkg;

	localparam int COORD_BITS  = 24;
	localparam int T_FRAC_BITS = 24;
	localparam int TOL_BITS    = 25;
	localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(168);
	localparam int T_CAP_LOG   = 33;
	localparam int QUOT_BITS   = T_CAP_LOG + 1;

	typedef enum logic [1:0] {
		ST_FOUND    = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_OUTSIDE  = 2'd2
	} status_t;

endpackage

// ===== design/segx_div_cell.sv =====
// one restoring division step for both quotients, passing its request on
module segx_div_cell #(
	parameter int DEN_W  = 49,
	parameter int QB     = 34,
	parameter int SIDE_W = 149
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [DEN_W-1:0]  in_ra,
	input  logic [DEN_W-1:0]  in_rb,
	input  logic [QB-1:0]     in_nla,
	input  logic [QB-1:0]     in_nlb,
	input  logic [QB-1:0]     in_qa,
	input  logic [QB-1:0]     in_qb,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [DEN_W-1:0]  out_den,
	output logic [DEN_W-1:0]  out_ra,
	output logic [DEN_W-1:0]  out_rb,
	output logic [QB-1:0]     out_nla,
	output logic [QB-1:0]     out_nlb,
	output logic [QB-1:0]     out_qa,
	output logic [QB-1:0]     out_qb,
	output logic [SIDE_W-1:0] out_side
);

	logic [DEN_W:0] rr_a, rr_b, dif_a, dif_b;
	logic           ge_a, ge_b;

	always_comb begin
		rr_a  = {in_ra, in_nla[QB-1]};
		rr_b  = {in_rb, in_nlb[QB-1]};
		dif_a = rr_a - {1'b0, in_den};
		dif_b = rr_b - {1'b0, in_den};
		ge_a  = rr_a >= {1'b0, in_den};
		ge_b  = rr_b >= {1'b0, in_den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_den  <= in_den;
		out_ra   <= ge_a ? dif_a[DEN_W-1:0] : rr_a[DEN_W-1:0];
		out_rb   <= ge_b ? dif_b[DEN_W-1:0] : rr_b[DEN_W-1:0];
		out_nla  <= {in_nla[QB-2:0], 1'b0};
		out_nlb  <= {in_nlb[QB-2:0], 1'b0};
		out_qa   <= {in_qa[QB-2:0], ge_a};
		out_qb   <= {in_qb[QB-2:0], ge_b};
		out_side <= in_side;
	end

endmodule

// ===== design/segx_point.sv =====
// scaled offset along segment one, rounded, added to the start and saturated
module segx_point #(
	parameter int C    = 24,
	parameter int F    = 24,
	parameter int TM_W = 27
) (
	input  logic                clk,
	input  logic signed [C-1:0]    base,
	input  logic signed [C-1:0]    dir,
	input  logic signed [TM_W-1:0] t,
	input  logic                hit,
	output logic signed [C-1:0]    coord
);

	localparam int P_W = C + TM_W + 1;
	localparam int R_W = P_W - F;
	localparam int S_W = R_W + 1;
	localparam logic signed [P_W-1:0] HALF = {{(P_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
	localparam logic signed [S_W-1:0] HI = S_W'(2**(C-1) - 1);
	localparam logic signed [S_W-1:0] LO = S_W'(-(2**(C-1)));

	logic signed [C+TM_W-1:0] prod_s1;
	logic signed [C-1:0]      base_s1, base_s2;
	logic                     hit_s1, hit_s2;
	logic signed [R_W-1:0]    rnd_s2;
	logic signed [P_W-1:0]    psum;
	logic signed [S_W-1:0]    sum;

	always_comb begin
		psum = P_W'(prod_s1) + HALF;
		sum  = S_W'(rnd_s2) + S_W'(base_s2);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= dir * t;
		base_s1 <= base;
		hit_s1  <= hit;
		rnd_s2  <= signed'(psum[P_W-1:F]);
		base_s2 <= base_s1;
		hit_s2  <= hit_s1;
		if (!hit_s2) begin
			coord <= '0;
		end else if (sum > HI) begin
			coord <= HI[C-1:0];
		end else if (sum < LO) begin
			coord <= LO[C-1:0];
		end else begin
			coord <= sum[C-1:0];
		end
	end

endmodule

// ===== design/segment_intersection_xz.sv =====
// top level: crossing of two segments in the xz plane
//
// usage
//   a request is taken at every rising edge with start high; busy is always
//   low, so one pair of segments may follow another in every cycle
//   the tolerance register is written over cfg_valid / cfg_ready / cfg_data
//   by the user only while no request is in flight, which the block leaves
//   unchecked; cfg_ready is always high
//   each request gives one result, shown for one cycle with done high:
//   status (found, parallel, outside) and the crossing point, zero unless found
// pipeline
//   one request per cycle through the 34 cells of the quotient chain, one
//   quotient bit per cell, plus ten arithmetic stages
// reset
//   arst_n clears every valid flag, drops all requests in flight and sets
//   the tolerance to its reset value
// stalls
//   the receiver cannot stall; results leave on the cycle they are ready
module segment_intersection_xz #(
	parameter int COORD_BITS  = segx_pkg::COORD_BITS,
	parameter int T_FRAC_BITS = segx_pkg::T_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [segx_pkg::TOL_BITS-1:0] cfg_data,
	input  logic signed [COORD_BITS-1:0] start1_x,
	input  logic signed [COORD_BITS-1:0] start1_y,
	input  logic signed [COORD_BITS-1:0] start1_z,
	input  logic signed [COORD_BITS-1:0] dir1_x,
	input  logic signed [COORD_BITS-1:0] dir1_y,
	input  logic signed [COORD_BITS-1:0] dir1_z,
	input  logic signed [COORD_BITS-1:0] start2_x,
	input  logic signed [COORD_BITS-1:0] start2_z,
	input  logic signed [COORD_BITS-1:0] dir2_x,
	input  logic signed [COORD_BITS-1:0] dir2_z,
	output logic                         done,
	output logic [1:0]                   status,
	output logic signed [COORD_BITS-1:0] cross_x,
	output logic signed [COORD_BITS-1:0] cross_y,
	output logic signed [COORD_BITS-1:0] cross_z
);

	localparam int C       = COORD_BITS;
	localparam int F       = T_FRAC_BITS;
	localparam int QB      = segx_pkg::QUOT_BITS;
	localparam int TB      = segx_pkg::TOL_BITS;
	localparam int DEN_W   = 2*C + 1;
	localparam int NUM_W   = 2*C + 2;
	localparam int TOP_W   = NUM_W + F - QB;
	localparam int CRD_W   = 6*C;
	localparam int SIDE_W  = CRD_W + 5;
	localparam int T_W     = QB + 1;
	localparam int TM_W    = ((F > 25) ? F : 25) + 2;
	localparam int LATENCY = QB + 10;
	localparam logic [QB-1:0] T_CAP = {1'b1, {(QB-1){1'b0}}};
	localparam logic signed [T_W-1:0] T_ONE = T_W'(1) << F;

	// coordinate bundle: {s1x, s1y, s1z, d1x, d1y, d1z}
	localparam int K_S1X = 5;
	localparam int K_S1Y = 4;
	localparam int K_S1Z = 3;
	localparam int K_D1X = 2;
	localparam int K_D1Y = 1;
	localparam int K_D1Z = 0;

	logic [TB-1:0] tol_q;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [CRD_W-1:0]         crd_s1, crd_s2, crd_s3, crd_s4, crd_s6, crd_s7;
	logic signed [C:0]        wx_s1, wz_s1;
	logic signed [C-1:0]      d2x_s1, d2z_s1;
	logic signed [2*C-1:0]    pda_s2, pdb_s2;
	logic signed [2*C:0]      paa_s2, pab_s2, pba_s2, pbb_s2;
	logic signed [DEN_W-1:0]  den_s3;
	logic signed [NUM_W-1:0]  na_s3, nb_s3;
	logic                     par_s4, nega_s4, negb_s4;
	logic [DEN_W-1:0]         den_s4;
	logic [NUM_W-1:0]         ma_s4, mb_s4;
	logic [DEN_W-1:0]         den_s5, ra_s5, rb_s5;
	logic [QB-1:0]            nla_s5, nlb_s5;
	logic [SIDE_W-1:0]        side_s5;
	logic signed [T_W-1:0]    ta_s6, tb_s6;
	logic                     par_s6;
	logic signed [TM_W-1:0]   ta_s7;
	segx_pkg::status_t        st_s7, st_s8, st_s9, st_q;

	logic [NUM_W+F-1:0]       nfa, nfb;
	logic [TOP_W-1:0]         topa, topb;
	logic [QB-1:0]            maga, magb;
	logic signed [T_W-1:0]    tol_ext, t_lo, t_hi;
	logic                     ina, inb;
	logic [SIDE_W-1:0]        side_end;
	logic [CRD_W-1:0]         crd_end;
	logic                     nega_e, negb_e, sata_e, satb_e, par_e;

	logic              c_v    [0:QB];
	logic [DEN_W-1:0]  c_den  [0:QB];
	logic [DEN_W-1:0]  c_ra   [0:QB];
	logic [DEN_W-1:0]  c_rb   [0:QB];
	logic [QB-1:0]     c_nla  [0:QB];
	logic [QB-1:0]     c_nlb  [0:QB];
	logic [QB-1:0]     c_qa   [0:QB];
	logic [QB-1:0]     c_qb   [0:QB];
	logic [SIDE_W-1:0] c_side [0:QB];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= segx_pkg::TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= c_v[QB];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			done <= v_s9;
		end
	end

	// front: offsets, products, cross products, magnitudes
	always_ff @(posedge clk) begin
		crd_s1 <= {start1_x, start1_y, start1_z, dir1_x, dir1_y, dir1_z};
		wx_s1  <= (C+1)'(start2_x) - (C+1)'(start1_x);
		wz_s1  <= (C+1)'(start2_z) - (C+1)'(start1_z);
		d2x_s1 <= dir2_x;
		d2z_s1 <= dir2_z;

		crd_s2 <= crd_s1;
		pda_s2 <= signed'(crd_s1[K_D1X*C +: C]) * d2z_s1;
		pdb_s2 <= signed'(crd_s1[K_D1Z*C +: C]) * d2x_s1;
		paa_s2 <= wx_s1 * d2z_s1;
		pab_s2 <= wz_s1 * d2x_s1;
		pba_s2 <= wx_s1 * signed'(crd_s1[K_D1Z*C +: C]);
		pbb_s2 <= wz_s1 * signed'(crd_s1[K_D1X*C +: C]);

		crd_s3 <= crd_s2;
		den_s3 <= DEN_W'(pda_s2) - DEN_W'(pdb_s2);
		na_s3  <= NUM_W'(paa_s2) - NUM_W'(pab_s2);
		nb_s3  <= NUM_W'(pba_s2) - NUM_W'(pbb_s2);

		crd_s4  <= crd_s3;
		par_s4  <= den_s3 == '0;
		den_s4  <= den_s3[DEN_W-1] ? DEN_W'(-den_s3) : DEN_W'(den_s3);
		ma_s4   <= na_s3[NUM_W-1] ? NUM_W'(-na_s3) : NUM_W'(na_s3);
		mb_s4   <= nb_s3[NUM_W-1] ? NUM_W'(-nb_s3) : NUM_W'(nb_s3);
		nega_s4 <= na_s3[NUM_W-1] ^ den_s3[DEN_W-1];
		negb_s4 <= nb_s3[NUM_W-1] ^ den_s3[DEN_W-1];
	end

	// quotient chain entry
	always_comb begin
		nfa  = {ma_s4, {F{1'b0}}};
		nfb  = {mb_s4, {F{1'b0}}};
		topa = nfa[NUM_W+F-1:QB];
		topb = nfb[NUM_W+F-1:QB];
	end

	always_ff @(posedge clk) begin
		den_s5  <= den_s4;
		ra_s5   <= DEN_W'(topa);
		rb_s5   <= DEN_W'(topb);
		nla_s5  <= nfa[QB-1:0];
		nlb_s5  <= nfb[QB-1:0];
		side_s5 <= {crd_s4, nega_s4, negb_s4,
			DEN_W'(topa) >= den_s4, DEN_W'(topb) >= den_s4, par_s4};
	end

	assign c_v[0]    = v_s5;
	assign c_den[0]  = den_s5;
	assign c_ra[0]   = ra_s5;
	assign c_rb[0]   = rb_s5;
	assign c_nla[0]  = nla_s5;
	assign c_nlb[0]  = nlb_s5;
	assign c_qa[0]   = '0;
	assign c_qb[0]   = '0;
	assign c_side[0] = side_s5;

	for (genvar k = 0; k < QB; k++) begin : g_cell
		segx_div_cell #(
			.DEN_W  (DEN_W),
			.QB     (QB),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_v[k]),
			.in_den    (c_den[k]),
			.in_ra     (c_ra[k]),
			.in_rb     (c_rb[k]),
			.in_nla    (c_nla[k]),
			.in_nlb    (c_nlb[k]),
			.in_qa     (c_qa[k]),
			.in_qb     (c_qb[k]),
			.in_side   (c_side[k]),
			.out_valid (c_v[k+1]),
			.out_den   (c_den[k+1]),
			.out_ra    (c_ra[k+1]),
			.out_rb    (c_rb[k+1]),
			.out_nla   (c_nla[k+1]),
			.out_nlb   (c_nlb[k+1]),
			.out_qa    (c_qa[k+1]),
			.out_qb    (c_qb[k+1]),
			.out_side  (c_side[k+1])
		);
	end

	// back: signed t, bounds, crossing point
	always_comb begin
		side_end = c_side[QB];
		{crd_end, nega_e, negb_e, sata_e, satb_e, par_e} = side_end;
		maga = (sata_e || c_qa[QB] > T_CAP) ? T_CAP : c_qa[QB];
		magb = (satb_e || c_qb[QB] > T_CAP) ? T_CAP : c_qb[QB];
		tol_ext = signed'(T_W'(tol_q));
		t_lo    = -tol_ext;
		t_hi    = T_ONE + tol_ext;
		ina     = !(ta_s6 < t_lo) && !(ta_s6 > t_hi);
		inb     = !(tb_s6 < t_lo) && !(tb_s6 > t_hi);
	end

	always_ff @(posedge clk) begin
		crd_s6 <= crd_end;
		par_s6 <= par_e;
		ta_s6  <= nega_e ? -signed'({1'b0, maga}) : signed'({1'b0, maga});
		tb_s6  <= negb_e ? -signed'({1'b0, magb}) : signed'({1'b0, magb});

		crd_s7 <= crd_s6;
		ta_s7  <= ta_s6[TM_W-1:0];
		if (par_s6) begin
			st_s7 <= segx_pkg::ST_PARALLEL;
		end else if (ina && inb) begin
			st_s7 <= segx_pkg::ST_FOUND;
		end else begin
			st_s7 <= segx_pkg::ST_OUTSIDE;
		end

		st_s8 <= st_s7;
		st_s9 <= st_s8;
		st_q  <= st_s9;
	end

	assign status = st_q;

	segx_point #(.C(C), .F(F), .TM_W(TM_W)) u_point_x (
		.clk   (clk),
		.base  (signed'(crd_s7[K_S1X*C +: C])),
		.dir   (signed'(crd_s7[K_D1X*C +: C])),
		.t     (ta_s7),
		.hit   (st_s7 == segx_pkg::ST_FOUND),
		.coord (cross_x)
	);

	segx_point #(.C(C), .F(F), .TM_W(TM_W)) u_point_y (
		.clk   (clk),
		.base  (signed'(crd_s7[K_S1Y*C +: C])),
		.dir   (signed'(crd_s7[K_D1Y*C +: C])),
		.t     (ta_s7),
		.hit   (st_s7 == segx_pkg::ST_FOUND),
		.coord (cross_y)
	);

	segx_point #(.C(C), .F(F), .TM_W(TM_W)) u_point_z (
		.clk   (clk),
		.base  (signed'(crd_s7[K_S1Z*C +: C])),
		.dir   (signed'(crd_s7[K_D1Z*C +: C])),
		.t     (ta_s7),
		.hit   (st_s7 == segx_pkg::ST_FOUND),
		.coord (cross_z)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("request without result");
	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != segx_pkg::ST_FOUND) |->
		(cross_x == '0 && cross_y == '0 && cross_z == '0))
		else $error("nonzero point without crossing");
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> tol_q == $past(cfg_data))
		else $error("tolerance write lost");
`endif

endmodule
